// ----- sv/text_to_unsigned_integer_parser_defines.svh -----
// Assertion macros for the text to unsigned integer parser checker.
// Depends on nothing; included by the checker file only.
`ifndef TEXT_TO_UNSIGNED_INTEGER_PARSER_DEFINES_SVH
`define TEXT_TO_UNSIGNED_INTEGER_PARSER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TUIP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define TUIP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/tuip_pkg.sv -----
// Shared types, constants and character helpers for the text to unsigned integer parser.
// Depends on nothing; used by the top level and its checker.
`default_nettype none

package tuip_pkg;

   localparam int unsigned MAX_CHARS_DEFAULT = 4095;

   localparam int unsigned CH_W       = 8;
   localparam int unsigned RADIX_W    = 6;
   localparam int unsigned VALUE_W    = 64;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned CONSUMED_W = 12;

   localparam logic [CONSUMED_W-1:0] CONSUMED_MAX = '1;

   localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
   localparam logic [RADIX_W-1:0] RADIX_ONE  = 6'd1;
   localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
   localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;
   localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;

   localparam logic [CH_W-1:0] DIGIT_NONE = 8'hff;

   localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CH_W-1:0] CH_PLUS    = 8'h2b;
   localparam logic [CH_W-1:0] CH_MINUS   = 8'h2d;
   localparam logic [CH_W-1:0] CH_X_LOWER = 8'h78;
   localparam logic [CH_W-1:0] CH_X_UPPER = 8'h58;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_RADIX = 2'd1,
      STATUS_RANGE     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SPACE,
      PH_SIGNED,
      PH_ZERO,
      PH_DIGITS
   } phase_type;

   // Digit weight of an ASCII character, DIGIT_NONE when it is no digit in any radix.
   function automatic logic [CH_W-1:0] digit_value(input logic [CH_W-1:0] c);
      logic [CH_W-1:0] d;
      d = DIGIT_NONE;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         d = c - 8'h61 + 8'd10;
      end else if (c >= 8'h41 && c <= 8'h5a) begin
         d = c - 8'h41 + 8'd10;
      end
      return d;
   endfunction

   // Space, tab, newline, vertical tab, form feed, carriage return.
   function automatic logic is_space(input logic [CH_W-1:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
   endfunction

endpackage

`default_nettype wire

// ----- sv/text_to_unsigned_integer_parser.sv -----
// Streaming unsigned integer parser: one character beat in, at most one number out.
// Depends on tuip_pkg.
//
//   port group   dir   handshake            payload
//   req_         in    req_valid/req_stall  req_ch, req_start_req
//   rsp_         out   rsp_valid/rsp_stall  rsp_value, rsp_status, rsp_consumed
//   csr_         in    csr_wr_en            csr_wr_data (radix)
//
// One character per cycle while the result is not stalled. A beat is held in the input
// register, then the 64x6 multiply-add and overflow check update the state and load the result
// register; a result is valid once its character has passed the input and the result register.
// Synchronous reset clears the parser state and both valid flags.
// A stalled result holds the result register; one more beat is taken into the
// input register and held there until the result is taken.
`default_nettype none

module text_to_unsigned_integer_parser
   import tuip_pkg::*;
#(
   parameter int unsigned MAX_CHARS = MAX_CHARS_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire  [CH_W-1:0]        req_ch,
   input  wire                    req_start_req,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output logic [VALUE_W-1:0]     rsp_value,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [CONSUMED_W-1:0]  rsp_consumed,
   input  wire                    csr_wr_en,
   input  wire  [RADIX_W-1:0]     csr_wr_data
);

   localparam int unsigned CNT_W  = $clog2(MAX_CHARS + 1);
   localparam int unsigned WIDE_W = (CNT_W > CONSUMED_W) ? CNT_W : CONSUMED_W;
   localparam int unsigned PROD_W = VALUE_W + RADIX_W;

   // configuration
   logic [RADIX_W-1:0] radix_ff;

   // input register
   logic            in_valid_ff, in_valid_in;
   logic [CH_W-1:0] ch_ff;
   logic            start_ff;

   // parser state
   phase_type           phase_ff, phase_in;
   logic [RADIX_W-1:0]  radix_use_ff, radix_use_in;
   logic                neg_ff, neg_in;
   logic [VALUE_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]    rsp_value_ff;
   status_type            rsp_status_ff;
   logic [CONSUMED_W-1:0] rsp_consumed_ff;

   // state as seen by the current beat, after a start
   phase_type          s_phase;
   logic [RADIX_W-1:0] s_radix;
   logic               s_neg;
   logic [VALUE_W-1:0] s_acc;
   logic [CNT_W-1:0]   s_cnt;

   logic               fire;
   logic               bad_radix;
   logic [RADIX_W-1:0] dig_radix;
   logic [CH_W-1:0]    dig;
   logic               is_digit;
   logic [PROD_W-1:0]  prod;
   logic               ovf;
   logic [CNT_W-1:0]   cnt_inc;
   logic               first_step;
   logic               digit_step;
   logic               emit;
   logic [VALUE_W-1:0] res_value;
   status_type         res_status;
   logic [CNT_W-1:0]   res_cnt;
   logic [WIDE_W-1:0]  res_cnt_wide;

   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;

   assign in_valid_in  = (req_valid && !req_stall) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (fire && emit) ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   assign bad_radix = (radix_ff == RADIX_ONE) || (radix_ff > RADIX_MAX);

   always_comb begin
      s_phase = phase_ff;
      s_radix = radix_use_ff;
      s_neg   = neg_ff;
      s_acc   = acc_ff;
      s_cnt   = cnt_ff;
      if (start_ff) begin
         s_phase = PH_SPACE;
         s_radix = radix_ff;
         s_neg   = 1'b0;
         s_acc   = '0;
         s_cnt   = '0;
      end
   end

   // radix the digit unit works in for this beat
   always_comb begin
      dig_radix = s_radix;
      if (s_radix == RADIX_AUTO) begin
         dig_radix = (s_phase == PH_ZERO) ? RADIX_OCT : RADIX_DEC;
      end
   end

   assign dig      = digit_value(ch_ff);
   assign is_digit = dig < CH_W'(dig_radix);
   assign prod     = PROD_W'(s_acc) * PROD_W'(dig_radix) + PROD_W'(dig);
   assign ovf      = |prod[PROD_W-1:VALUE_W];
   assign cnt_inc  = (s_cnt < CNT_W'(MAX_CHARS)) ? s_cnt + 1'b1 : s_cnt;

   always_comb begin
      phase_in     = s_phase;
      radix_use_in = s_radix;
      neg_in       = s_neg;
      acc_in       = s_acc;
      cnt_in       = s_cnt;
      emit         = 1'b0;
      res_value    = s_acc;
      res_status   = STATUS_OK;
      res_cnt      = s_cnt;
      first_step   = 1'b0;
      digit_step   = 1'b0;

      if (start_ff && bad_radix) begin
         emit       = 1'b1;
         res_value  = '0;
         res_status = STATUS_BAD_RADIX;
         res_cnt    = '0;
         phase_in   = PH_IDLE;
      end else begin
         unique case (s_phase)
            PH_IDLE: begin
               // drop characters until the next start
            end
            PH_SPACE: begin
               if (is_space(ch_ff)) begin
                  cnt_in = cnt_inc;
               end else if (ch_ff == CH_PLUS || ch_ff == CH_MINUS) begin
                  neg_in   = (ch_ff == CH_MINUS);
                  cnt_in   = cnt_inc;
                  phase_in = PH_SIGNED;
               end else begin
                  first_step = 1'b1;
               end
            end
            PH_SIGNED: begin
               first_step = 1'b1;
            end
            PH_ZERO: begin
               if (ch_ff == CH_X_LOWER || ch_ff == CH_X_UPPER) begin
                  cnt_in   = cnt_inc;
                  phase_in = PH_DIGITS;
                  if (s_radix == RADIX_AUTO) begin
                     radix_use_in = RADIX_HEX;
                  end
               end else begin
                  radix_use_in = dig_radix;
                  digit_step   = 1'b1;
               end
            end
            PH_DIGITS: begin
               digit_step = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      // first character after space and sign: maybe the start of a 0x prefix
      if (first_step) begin
         if ((s_radix == RADIX_AUTO || s_radix == RADIX_HEX) && ch_ff == CH_ZERO) begin
            cnt_in   = cnt_inc;
            phase_in = PH_ZERO;
         end else begin
            radix_use_in = dig_radix;
            digit_step   = 1'b1;
         end
      end

      if (digit_step) begin
         phase_in = PH_DIGITS;
         if (!is_digit) begin
            emit      = 1'b1;
            res_value = s_neg ? (VALUE_W'(0) - s_acc) : s_acc;
            phase_in  = PH_IDLE;
         end else if (ovf) begin
            emit       = 1'b1;
            res_value  = '1;
            res_status = STATUS_RANGE;
            phase_in   = PH_IDLE;
         end else begin
            acc_in = prod[VALUE_W-1:0];
            cnt_in = cnt_inc;
         end
      end
   end

   assign res_cnt_wide = WIDE_W'(res_cnt);

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= RADIX_AUTO;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         radix_use_ff <= RADIX_AUTO;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            radix_ff <= csr_wr_data;
         end
         if (fire) begin
            phase_ff     <= phase_in;
            radix_use_ff <= radix_use_in;
            neg_ff       <= neg_in;
            acc_ff       <= acc_in;
            cnt_ff       <= cnt_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         ch_ff    <= req_ch;
         start_ff <= req_start_req;
      end
      if (fire && emit) begin
         rsp_value_ff    <= res_value;
         rsp_status_ff   <= res_status;
         rsp_consumed_ff <= (res_cnt_wide > WIDE_W'(CONSUMED_MAX)) ?
                            CONSUMED_MAX : res_cnt_wide[CONSUMED_W-1:0];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_consumed = rsp_consumed_ff;

endmodule

`default_nettype wire

// ----- sv/tuip_checker.sv -----
// Port-level checks for the text to unsigned integer parser, bound to the top level.
// Depends on tuip_pkg and text_to_unsigned_integer_parser_defines.svh.
`default_nettype none

`include "text_to_unsigned_integer_parser_defines.svh"

module tuip_checker
   import tuip_pkg::*;
(
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_stall,
   input wire  [CH_W-1:0]        req_ch,
   input wire                    req_start_req,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input wire  [VALUE_W-1:0]     rsp_value,
   input wire  [STATUS_W-1:0]    rsp_status,
   input wire  [CONSUMED_W-1:0]  rsp_consumed,
   input wire                    csr_wr_en,
   input wire  [RADIX_W-1:0]     csr_wr_data
);

   logic rsp_beat;
   assign rsp_beat = rsp_valid && !rsp_stall;

   // a stalled result beat stays up and holds its value
   `TUIP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
   `TUIP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_value) && $stable(rsp_status) && $stable(rsp_consumed), "stalled result changed")

   // bad radix reports nothing consumed and a zero value
   `TUIP_ASSERT(a_bad_radix, clock, reset, !(rsp_beat && rsp_status == STATUS_BAD_RADIX) || (rsp_value == '0 && rsp_consumed == '0), "bad radix result not zero")

   // overflow always saturates to all ones
   `TUIP_ASSERT(a_range_ones, clock, reset, !(rsp_beat && rsp_status == STATUS_RANGE) || (&rsp_value), "range result not all ones")

   `TUIP_ASSERT(a_status_code, clock, reset, !rsp_valid || rsp_status == STATUS_OK || rsp_status == STATUS_BAD_RADIX || rsp_status == STATUS_RANGE, "unknown status code")

endmodule

bind text_to_unsigned_integer_parser tuip_checker u_tuip_checker (.*);

`default_nettype wire

// ----- test/text_to_unsigned_integer_parser_test.sv -----
// Self-checking bench for the streaming unsigned integer parser: directed strings, then random
// text under several radix settings, each number compared with an in-bench parse of the text.
// Depends on tuip_pkg and text_to_unsigned_integer_parser.
`timescale 1ns / 1ps

module text_to_unsigned_integer_parser_test;
   import tuip_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [VALUE_W-1:0]    value;
      status_type            status;
      logic [CONSUMED_W-1:0] consumed;
   } parsed_number_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CH_W-1:0]       req_ch = '0;
   logic                  req_start_req = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VALUE_W-1:0]    rsp_value;
   logic [STATUS_W-1:0]   rsp_status;
   logic [CONSUMED_W-1:0] rsp_consumed;
   logic                  csr_wr_en = 1'b0;
   logic [RADIX_W-1:0]    csr_wr_data = '0;

   // parser state as seen from the text
   logic [RADIX_W-1:0]    radix_reg = RADIX_AUTO;
   phase_type             parse_phase = PH_IDLE;
   logic [RADIX_W-1:0]    active_base = '0;
   logic                  minus_seen = 1'b0;
   logic [VALUE_W-1:0]    accum = '0;
   logic [CONSUMED_W-1:0] taken = '0;

   parsed_number_type     expected_numbers[$];
   parsed_number_type     oldest;
   logic [CH_W-1:0]       text_beats[$];
   bit                    text_noise;
   bit                    no_gaps = 1'b0;
   int                    useful_chars = 0;
   int                    errors = 0;
   int unsigned           cycle_count = 0;

   text_to_unsigned_integer_parser dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ch        (req_ch),
      .req_start_req (req_start_req),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status),
      .rsp_consumed  (rsp_consumed),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !no_gaps && ($urandom_range(0, 99) < 20);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("text_to_unsigned_integer_parser verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- parse model

   function automatic logic [CH_W-1:0] char_weight(input logic [CH_W-1:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "z") return c - "a" + 8'd10;
      if (c >= "A" && c <= "Z") return c - "A" + 8'd10;
      return DIGIT_NONE;
   endfunction

   function automatic bit is_blank(input logic [CH_W-1:0] c);
      return c == " " || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic void count_char();
      if (taken < MAX_CHARS_DEFAULT) taken++;
   endfunction

   function automatic parsed_number_type close_number(input logic [VALUE_W-1:0] v,
                                                      input status_type s,
                                                      input logic [CONSUMED_W-1:0] n);
      parsed_number_type r;
      r.value = v;
      r.status = s;
      r.consumed = n;
      parse_phase = PH_IDLE;
      return r;
   endfunction

   function automatic bit take_digit(input logic [CH_W-1:0] c, output parsed_number_type r);
      logic [CH_W-1:0] w;
      logic [VALUE_W+5:0] wide;
      w = char_weight(c);
      parse_phase = PH_DIGITS;
      if (w >= {2'b00, active_base}) begin
         r = close_number(minus_seen ? 64'd0 - accum : accum, STATUS_OK, taken);
         return 1'b1;
      end
      wide = {6'd0, accum} * {64'd0, active_base} + {62'd0, w};
      // anything above bit 63 means the digit pushes past all ones
      if (wide[VALUE_W+5:VALUE_W] != '0) begin
         r = close_number('1, STATUS_RANGE, taken);
         return 1'b1;
      end
      accum = wide[VALUE_W-1:0];
      count_char();
      return 1'b0;
   endfunction

   function automatic bit take_first(input logic [CH_W-1:0] c, output parsed_number_type r);
      if ((active_base == RADIX_AUTO || active_base == RADIX_HEX) && c == CH_ZERO) begin
         count_char();
         parse_phase = PH_ZERO;
         return 1'b0;
      end
      if (active_base == RADIX_AUTO) active_base = RADIX_DEC;
      return take_digit(c, r);
   endfunction

   function automatic bit parse_char(input logic [CH_W-1:0] c, input bit start,
                                     output parsed_number_type r);
      if (start) begin
         active_base = radix_reg;
         minus_seen = 1'b0;
         accum = '0;
         taken = '0;
         if (active_base == RADIX_ONE || active_base > RADIX_MAX) begin
            r = close_number('0, STATUS_BAD_RADIX, '0);
            return 1'b1;
         end
         parse_phase = PH_SPACE;
      end
      case (parse_phase)
         PH_SPACE: begin
            if (is_blank(c)) begin
               count_char();
               return 1'b0;
            end
            if (c == CH_PLUS || c == CH_MINUS) begin
               minus_seen = (c == CH_MINUS);
               count_char();
               parse_phase = PH_SIGNED;
               return 1'b0;
            end
            return take_first(c, r);
         end
         PH_SIGNED: return take_first(c, r);
         PH_ZERO: begin
            if (c == CH_X_LOWER || c == CH_X_UPPER) begin
               count_char();
               if (active_base == RADIX_AUTO) active_base = RADIX_HEX;
               parse_phase = PH_DIGITS;
               return 1'b0;
            end
            if (active_base == RADIX_AUTO) active_base = RADIX_OCT;
            return take_digit(c, r);
         end
         PH_DIGITS: return take_digit(c, r);
         default: return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------- result check

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_numbers.size() == 0) begin
            $display("%0t: unexpected number: value %h status %0d consumed %0d",
                     $time, rsp_value, rsp_status, rsp_consumed);
            errors++;
         end else begin
            oldest = expected_numbers.pop_front();
            if (rsp_value !== oldest.value) begin
               $display("%0t: value expected %h actual %h", $time, oldest.value, rsp_value);
               errors++;
            end
            if (rsp_status !== oldest.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, oldest.status, rsp_status);
               errors++;
            end
            if (rsp_consumed !== oldest.consumed) begin
               $display("%0t: consumed expected %0d actual %0d",
                        $time, oldest.consumed, rsp_consumed);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- drive

   task automatic send_char(input logic [CH_W-1:0] c, input bit start);
      parsed_number_type num;
      if (!no_gaps && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      req_start_req <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (start || parse_phase != PH_IDLE) useful_chars++;
      if (parse_char(c, start, num)) expected_numbers = {expected_numbers, num};
   endtask

   task automatic send_text(input string s, input bit first_start);
      int i;
      for (i = 0; i < s.len(); i++) send_char(s[i], first_start && i == 0);
   endtask

   // wait out every number in flight plus any beat that gives none
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_numbers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_radix(input logic [RADIX_W-1:0] r);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= r;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      radix_reg = r;
   endtask

   // ---------------------------------------------------------------- random text

   function automatic void add_beat(input logic [CH_W-1:0] c);
      text_beats = {text_beats, c};
   endfunction

   function automatic logic [CH_W-1:0] weight_char(input int w);
      if (w < 10) return 8'("0" + w);
      return 8'(($urandom_range(0, 1) ? "a" : "A") + w - 10);
   endfunction

   function automatic logic [CH_W-1:0] pick_blank();
      return $urandom_range(0, 2) == 0 ? " " : 8'($urandom_range(9, 13));
   endfunction

   function automatic logic [CH_W-1:0] pick_end();
      case ($urandom_range(0, 4))
         0: return " ";
         1: return ",";
         2: return 8'h00;
         3: return 8'hff;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic build_number(input logic [RADIX_W-1:0] base);
      int i, eff, ndig, w, style;
      bit lead_nonzero;
      text_beats.delete();
      text_noise = ($urandom_range(0, 99) < 10);
      if (text_noise) begin
         repeat ($urandom_range(1, 6)) add_beat(8'($urandom_range(0, 255)));
         return;
      end
      repeat ($urandom_range(0, 2)) add_beat(pick_blank());
      case ($urandom_range(0, 9))
         0, 1: add_beat(CH_PLUS);
         2, 3: add_beat(CH_MINUS);
         default: ;
      endcase
      // a second sign now and then ends the number early
      if ($urandom_range(0, 29) == 0) add_beat(CH_MINUS);
      eff = base;
      lead_nonzero = 1'b0;
      if (base == RADIX_AUTO) begin
         style = $urandom_range(0, 2);
         if (style < 2) add_beat(CH_ZERO);
         if (style == 0) begin
            add_beat($urandom_range(0, 1) ? CH_X_LOWER : CH_X_UPPER);
            eff = RADIX_HEX;
         end else if (style == 1) begin
            eff = RADIX_OCT;
         end else begin
            eff = RADIX_DEC;
            lead_nonzero = 1'b1;
         end
      end else if (base == RADIX_HEX && $urandom_range(0, 2) == 0) begin
         add_beat(CH_ZERO);
         add_beat($urandom_range(0, 1) ? CH_X_LOWER : CH_X_UPPER);
      end else if (base == RADIX_ONE || base > RADIX_MAX) begin
         eff = RADIX_DEC;
      end
      // mostly short numbers; long runs of heavy digits go after overflow
      ndig = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(12, 70);
      for (i = 0; i < ndig; i++) begin
         if (ndig > 8) w = $urandom_range(eff / 2, eff - 1);
         else w = $urandom_range((lead_nonzero && i == 0) ? 1 : 0, eff - 1);
         add_beat(weight_char(w));
      end
      if ($urandom_range(0, 9) != 0) add_beat(pick_end());
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 3)) add_beat(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_number();
      int i;
      for (i = 0; i < text_beats.size(); i++) begin
         if (i == 0) send_char(text_beats[i], 1'b1);
         else send_char(text_beats[i], text_noise && $urandom_range(0, 3) == 0);
      end
   endtask

   // ---------------------------------------------------------------- tests

   // radix register still at its reset value: automatic detection
   task automatic test_auto_radix();
      send_text("  +0x1fZ", 1'b1);
      send_text("017 ", 1'b1);
      send_text("09", 1'b1);
      send_text("-42,", 1'b1);
      send_text("0Xg", 1'b1);
      send_text("+!", 1'b1);
      send_text("--3", 1'b1);
      send_char(8'h09, 1'b1);
      send_char(8'h0a, 1'b0);
      send_char(8'h0b, 1'b0);
      send_char(8'h0c, 1'b0);
      send_char(8'h0d, 1'b0);
      send_text(" 7;", 1'b0);
      send_char(8'h80, 1'b1);
      send_char(8'hff, 1'b1);
      send_text("0 ", 1'b1);
      // abandon a number half way with a fresh start
      send_text("12", 1'b1);
      send_text("5 ", 1'b1);
      send_text("99", 1'b0);
   endtask

   task automatic test_fixed_radix();
      set_radix(6'd2);
      send_text("1012", 1'b1);
      set_radix(RADIX_MAX);
      send_text("zZ9.", 1'b1);
      set_radix(RADIX_HEX);
      send_text("0x10 ", 1'b1);
      send_text("0xg", 1'b1);
      send_text("-ff ", 1'b1);
      set_radix(RADIX_OCT);
      send_text("0x7", 1'b1);
      set_radix(RADIX_DEC);
      send_text("0x5", 1'b1);
      send_text("007 ", 1'b1);
      set_radix(RADIX_ONE);
      send_text("5-1", 1'b1);
      set_radix(6'd37);
      send_text("1", 1'b1);
      set_radix(6'd63);
      send_text("9", 1'b1);
   endtask

   task automatic test_overflow();
      set_radix(RADIX_DEC);
      send_text("18446744073709551615 ", 1'b1);
      send_text("18446744073709551616 9", 1'b1);
      send_text("-99999999999999999999", 1'b1);
      send_text("-1 ", 1'b1);
      set_radix(RADIX_AUTO);
      send_text("0xFFFFFFFFFFFFFFFF;", 1'b1);
      send_text("0x10000000000000000", 1'b1);
      set_radix(6'd2);
      send_char("1", 1'b1);
      repeat (64) send_char("1", 1'b0);
   endtask

   task automatic test_random_text();
      logic [RADIX_W-1:0] plan [0:11];
      int ph, first, numbers;
      plan = '{RADIX_AUTO, RADIX_DEC, RADIX_HEX, 6'd2, RADIX_MAX, RADIX_OCT,
               RADIX_AUTO, RADIX_ONE, 6'd37, 6'd63, 6'd0, 6'd0};
      plan[10] = 6'($urandom_range(2, 36));
      plan[11] = 6'($urandom_range(0, 63));
      for (ph = 0; ph < 12; ph++) begin
         set_radix(plan[ph]);
         // one long stretch with no gaps on either side
         no_gaps = (ph == 6);
         first = useful_chars;
         numbers = 0;
         while (useful_chars - first < 20 && numbers < 30) begin
            build_number(plan[ph]);
            send_number();
            numbers++;
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_auto_radix();
      test_fixed_radix();
      test_overflow();
      test_random_text();
      drain();
      if (errors == 0) begin
         $display("text_to_unsigned_integer_parser verification clean");
      end else begin
         $display("text_to_unsigned_integer_parser verification failed");
      end
      $finish;
   end

endmodule
